@@ rtl/ctgt_pkg.sv @@
package ctgt_pkg;

  // Sizing of the bitmap and the report
  localparam int MAX_CHUNKS = 4096;
  localparam int MAX_RANGES = 48;
  localparam int WORD_W     = 32;
  localparam int MAP_WORDS  = (MAX_CHUNKS + WORD_W - 1) / WORD_W;
  localparam int WADDR_W    = $clog2(MAP_WORDS);
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int CNT_W      = 13;
  localparam int SEQ_W      = 16;
  localparam int RCNT_W     = $clog2(MAX_RANGES + 1);

  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_CHUNK  = 2'd1,
    ACT_REPORT = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    ST_STARTED      = 3'd0,
    ST_STORED       = 3'd1,
    ST_DUPLICATE    = 3'd2,
    ST_OUT_OF_RANGE = 3'd3,
    ST_GAP          = 3'd4,
    ST_COMPLETE     = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_CHK,
    S_RPT_RD,
    S_RPT_SCAN,
    S_FLUSH
  } state_t;

  // Result of searching one bitmap word for the next gap edge
  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] bitpos;
    logic             last_word;
  } scan_res_t;

endpackage

@@ rtl/chunk_receive_gap_tracker.sv @@
// Channel  Dir  Beat fields (tdata / tuser / tlast)
// s_*      in   seq / action / -
// m_*      out  range_start, range_end, received_count / status / last
// cfg_*    in   total_chunks (13 bits), always ready
//
// Start and out of range are accepted, then pass through S_PUSH into the result register; an unused
// action is accepted with no result; a chunk reads its bitmap word, then sets a new bit in S_CHK.
// A report alternates a word read (S_RPT_RD) with a scan of it (S_RPT_SCAN), staying on the word
// for each gap edge found, over the words up to the total and at most MAX_RANGES ranges. Reset clears
// the per-word valid flags at once, so no clearing pass is needed. A stalled m_tready holds
// the result register; a new item is taken while it waits, but further results wait behind it.
module chunk_receive_gap_tracker
  import ctgt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [SEQ_W-1:0]  s_tdata,   // [15:0] seq
  input  logic [1:0]        s_tuser,   // [1:0] action
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [39:0]       m_tdata,   // [12:0] range_start, [25:13] range_end,
                                       // [38:26] received_count, [39] zero
  output logic [2:0]        m_tuser,   // [2:0] status
  output logic              m_tlast,   // last
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CNT_W-1:0]  cfg_data
);

  state_t state, state_next;

  logic [CNT_W-1:0]     total_chunks;
  logic [CNT_W-1:0]     eff_total;
  logic [CNT_W-1:0]     received_total;
  logic [MAP_WORDS-1:0] row_valid;
  logic                 rd_valid;

  logic                 ram_re, ram_we;
  logic [WADDR_W-1:0]   ram_raddr;
  logic [WORD_W-1:0]    ram_rdata, ram_wdata, cur_word;

  logic [WADDR_W-1:0]   chk_row, chk_row_next;
  logic [BIT_W-1:0]     chk_bit, chk_bit_next;
  status_t              hold_status, hold_status_next;

  logic [WADDR_W-1:0]   walk_row, walk_row_next;
  logic [BIT_W-1:0]     walk_pos, walk_pos_next;
  logic                 in_gap, in_gap_next;
  logic [CNT_W-1:0]     gap_start, gap_start_next;
  logic                 pend_valid, pend_valid_next;
  logic [CNT_W-1:0]     pend_start, pend_start_next;
  logic [CNT_W-1:0]     pend_end, pend_end_next;
  logic [RCNT_W-1:0]    rcount, rcount_next;

  logic                 out_valid;
  status_t              out_status;
  logic [CNT_W-1:0]     out_start, out_end, out_count;
  logic                 out_last;
  logic                 out_free;

  logic                 push, push_last, clear, count_inc;
  status_t              push_status;
  logic [CNT_W-1:0]     push_start, push_end, push_count;
  logic                 in_accept;
  action_t              in_action;
  scan_res_t            scan;
  logic [CNT_W-1:0]     gap_end;

  // Configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      total_chunks <= '0;
    end else if (cfg_valid) begin
      total_chunks <= cfg_data;
    end
  end

  assign eff_total = (total_chunks > CNT_W'(MAX_CHUNKS)) ? CNT_W'(MAX_CHUNKS) : total_chunks;

  assign s_tready  = (state == S_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign in_action = action_t'(s_tuser);
  assign out_free  = !out_valid || m_tready;

  // Bitmap storage
  ctgt_map_ram #(
    .DEPTH (MAP_WORDS),
    .WIDTH (WORD_W)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (chk_row),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // A word never written since the last clear reads as zero
  assign cur_word = rd_valid ? ram_rdata : '0;

  ctgt_word_scan u_scan (
    .word   (cur_word),
    .pos    (walk_pos),
    .in_gap (in_gap),
    .row    (walk_row),
    .total  (eff_total),
    .res    (scan)
  );

  assign gap_end = scan.found ? CNT_W'({walk_row, scan.bitpos}) : eff_total;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, memory control and result selection
  always_comb begin
    state_next       = state;
    chk_row_next     = chk_row;
    chk_bit_next     = chk_bit;
    hold_status_next = hold_status;
    walk_row_next    = walk_row;
    walk_pos_next    = walk_pos;
    in_gap_next      = in_gap;
    gap_start_next   = gap_start;
    pend_valid_next  = pend_valid;
    pend_start_next  = pend_start;
    pend_end_next    = pend_end;
    rcount_next      = rcount;
    ram_re           = 1'b0;
    ram_raddr        = walk_row;
    ram_we           = 1'b0;
    ram_wdata        = cur_word | (WORD_W'(1) << chk_bit);
    clear            = 1'b0;
    count_inc        = 1'b0;
    push             = 1'b0;
    push_status      = hold_status;
    push_start       = '0;
    push_end         = '0;
    push_count       = received_total;
    push_last        = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          case (in_action)
            ACT_START: begin
              clear            = 1'b1;
              hold_status_next = ST_STARTED;
              state_next       = S_PUSH;
            end
            ACT_CHUNK: begin
              if (s_tdata >= SEQ_W'(eff_total)) begin
                hold_status_next = ST_OUT_OF_RANGE;
                state_next       = S_PUSH;
              end else begin
                ram_re       = 1'b1;
                ram_raddr    = s_tdata[BIT_W +: WADDR_W];
                chk_row_next = s_tdata[BIT_W +: WADDR_W];
                chk_bit_next = s_tdata[BIT_W-1:0];
                state_next   = S_CHK;
              end
            end
            ACT_REPORT: begin
              walk_row_next   = '0;
              walk_pos_next   = '0;
              in_gap_next     = 1'b0;
              pend_valid_next = 1'b0;
              rcount_next     = '0;
              state_next      = (eff_total == '0) ? S_FLUSH : S_RPT_RD;
            end
            default: begin
            end
          endcase
        end
      end
      S_PUSH: begin
        if (out_free) begin
          push       = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_CHK: begin
        if (out_free) begin
          push = 1'b1;
          if (cur_word[chk_bit]) begin
            push_status = ST_DUPLICATE;
          end else begin
            ram_we      = 1'b1;
            count_inc   = 1'b1;
            push_status = ST_STORED;
            push_count  = received_total + 1'b1;
          end
          state_next = S_IDLE;
        end
      end
      S_RPT_RD: begin
        ram_re     = 1'b1;
        ram_raddr  = walk_row;
        state_next = S_RPT_SCAN;
      end
      S_RPT_SCAN: begin
        if (scan.found && !in_gap) begin
          // Open a gap
          in_gap_next    = 1'b1;
          gap_start_next = CNT_W'({walk_row, scan.bitpos});
          walk_pos_next  = scan.bitpos;
        end else if (scan.found || (scan.last_word && in_gap)) begin
          // Close a gap; the previous one goes out first
          if (!pend_valid || out_free) begin
            push            = pend_valid;
            push_status     = ST_GAP;
            push_start      = pend_start;
            push_end        = pend_end;
            push_last       = 1'b0;
            pend_valid_next = 1'b1;
            pend_start_next = gap_start;
            pend_end_next   = gap_end;
            rcount_next     = rcount + 1'b1;
            in_gap_next     = 1'b0;
            walk_pos_next   = scan.bitpos;
            if (!scan.found || (rcount + 1'b1 == RCNT_W'(MAX_RANGES))) begin
              state_next = S_FLUSH;
            end
          end
        end else if (scan.last_word) begin
          state_next = S_FLUSH;
        end else begin
          walk_row_next = walk_row + 1'b1;
          walk_pos_next = '0;
          state_next    = S_RPT_RD;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          push            = 1'b1;
          push_status     = pend_valid ? ST_GAP : ST_COMPLETE;
          push_start      = pend_valid ? pend_start : '0;
          push_end        = pend_valid ? pend_end : '0;
          pend_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Item and walk registers
  always_ff @(posedge clk) begin
    chk_row     <= chk_row_next;
    chk_bit     <= chk_bit_next;
    hold_status <= hold_status_next;
    walk_row    <= walk_row_next;
    walk_pos    <= walk_pos_next;
    in_gap      <= in_gap_next;
    gap_start   <= gap_start_next;
    pend_start  <= pend_start_next;
    pend_end    <= pend_end_next;
    rcount      <= rcount_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= pend_valid_next;
    end
  end

  // Word valid flags and the received count
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      row_valid      <= '0;
      received_total <= '0;
    end else begin
      if (ram_we) begin
        row_valid[chk_row] <= 1'b1;
      end
      if (count_inc) begin
        received_total <= received_total + 1'b1;
      end
    end
  end

  // Capture the valid flag with the read
  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_valid <= row_valid[ram_raddr];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_status <= push_status;
      out_start  <= push_start;
      out_end    <= push_end;
      out_count  <= push_count;
      out_last   <= push_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_count, out_end, out_start};
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;

  // Never overwrite a result that has not been taken
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    push |-> out_free)
    else $error("result pushed into a full output register");

  // Every emitted gap is non-empty
  a_gap_order: assert property (@(posedge clk) disable iff (rst)
    (push && push_status == ST_GAP) |-> (push_start < push_end))
    else $error("gap range with start not below end");

  // Range count never passes the limit
  a_range_limit: assert property (@(posedge clk) disable iff (rst)
    (state == S_RPT_SCAN || state == S_FLUSH) |-> (rcount <= RCNT_W'(MAX_RANGES)))
    else $error("range count above limit");

  // A start clears the bitmap flags and the count
  a_start_clear: assert property (@(posedge clk) disable iff (rst)
    (in_accept && in_action == ACT_START) |=> (row_valid == '0 && received_total == '0))
    else $error("start did not clear the bitmap");

  // A stored chunk bumps the count by one
  a_store_count: assert property (@(posedge clk) disable iff (rst)
    count_inc |=> (received_total == $past(received_total) + 1'b1))
    else $error("received count did not advance on a stored chunk");

endmodule

@@ rtl/ctgt_map_ram.sv @@
module ctgt_map_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/ctgt_word_scan.sv @@
module ctgt_word_scan
  import ctgt_pkg::*;
(
  input  logic [WORD_W-1:0]  word,
  input  logic [BIT_W-1:0]   pos,
  input  logic               in_gap,
  input  logic [WADDR_W-1:0] row,
  input  logic [CNT_W-1:0]   total,
  output scan_res_t          res
);

  logic [WORD_W-1:0] have;
  logic [WORD_W-1:0] target;
  logic [CNT_W-1:0]  next_base;

  // Bits at or past the total count as received so a gap closes there
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      have[b] = word[b] || (CNT_W'({row, BIT_W'(b)}) >= total);
    end
  end

  // Look for a received bit inside a gap, a missing bit outside one
  assign target = (in_gap ? have : ~have) & ({WORD_W{1'b1}} << pos);

  assign next_base = CNT_W'({row, {BIT_W{1'b0}}}) + CNT_W'(WORD_W);

  // Lowest matching bit
  always_comb begin
    res.found     = 1'b0;
    res.bitpos    = '0;
    res.last_word = (next_base >= total);
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (target[b]) begin
        res.found  = 1'b1;
        res.bitpos = BIT_W'(b);
      end
    end
  end

endmodule

@@ tb/sv/tb_chunk_receive_gap_tracker.sv @@
module tb_chunk_receive_gap_tracker;
  import ctgt_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES  = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 110;

  typedef enum logic [1:0] {
    OP_ITEM,
    OP_CFG,
    OP_SYNC,
    OP_MODE
  } op_kind_t;

  typedef struct {
    op_kind_t         kind;
    logic [1:0]       action;
    logic [SEQ_W-1:0] seq;
    logic [CNT_W-1:0] total;
    int               send_idle;
    int               stall;
    bit               hold;
  } stim_op_t;

  typedef struct {
    status_t          status;
    logic [CNT_W-1:0] range_start;
    logic [CNT_W-1:0] range_end;
    logic [CNT_W-1:0] count;
    logic             last;
  } gap_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [SEQ_W-1:0] s_tdata = '0;
  logic [1:0]       s_tuser = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [39:0]      m_tdata;
  logic [2:0]       m_tuser;
  logic             m_tlast;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;

  // Predicted block state
  logic [MAX_CHUNKS-1:0] rx_map = '0;
  logic [CNT_W-1:0]      rx_count = '0;
  logic [CNT_W-1:0]      total_cfg = '0;

  stim_op_t    stim_q[$];
  gap_result_t pending_results[$];
  int          mismatches = 0;

  // Driver-side control
  bit               offering = 1'b0;
  bit               cfg_busy = 1'b0;
  int               settle = 0;
  int               send_idle_pct = 0;
  int               stall_pct = 0;
  logic             hold_req = 1'b0;
  logic [1:0]       nxt_action = '0;
  logic [SEQ_W-1:0] nxt_seq = '0;
  logic [CNT_W-1:0] nxt_total = '0;

  always #10 clk = ~clk;

  chunk_receive_gap_tracker u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(string name, int got, int want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    end
  endtask

  task automatic push_result(status_t st, int rs, int re, logic is_last);
    gap_result_t r;
    r.status      = st;
    r.range_start = rs[CNT_W-1:0];
    r.range_end   = re[CNT_W-1:0];
    r.count       = rx_count;
    r.last        = is_last;
    pending_results.push_back(r);
  endtask

  // Update the tracked bitmap and queue the beats one action produces
  task automatic track_action(logic [1:0] action, logic [SEQ_W-1:0] seq);
    int          eff;
    int          n;
    int          gstart;
    bit          in_gap;
    gap_result_t r;
    eff = (total_cfg > MAX_CHUNKS) ? MAX_CHUNKS : int'(total_cfg);
    n = 0;
    gstart = 0;
    in_gap = 1'b0;
    case (action)
      ACT_START: begin
        rx_map = '0;
        rx_count = '0;
        push_result(ST_STARTED, 0, 0, 1'b1);
      end
      ACT_CHUNK: begin
        if (int'(seq) >= eff) begin
          push_result(ST_OUT_OF_RANGE, 0, 0, 1'b1);
        end else if (rx_map[seq]) begin
          push_result(ST_DUPLICATE, 0, 0, 1'b1);
        end else begin
          rx_map[seq] = 1'b1;
          rx_count = rx_count + 1'b1;
          push_result(ST_STORED, 0, 0, 1'b1);
        end
      end
      ACT_REPORT: begin
        for (int i = 0; i < eff && n < MAX_RANGES; i++) begin
          if (!rx_map[i] && !in_gap) begin
            gstart = i;
            in_gap = 1'b1;
          end
          if (rx_map[i] && in_gap) begin
            push_result(ST_GAP, gstart, i, 1'b0);
            n++;
            in_gap = 1'b0;
          end
        end
        // trailing gap only while room remains
        if (in_gap && n < MAX_RANGES) begin
          push_result(ST_GAP, gstart, eff, 1'b0);
          n++;
        end
        if (n == 0) begin
          push_result(ST_COMPLETE, 0, 0, 1'b1);
        end else begin
          r = pending_results.pop_back();
          r.last = 1'b1;
          pending_results.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  // Driver: offer queued beats, write the register once the block is idle
  always @(posedge clk) begin
    stim_op_t op;
    logic     hold_now;
    if (rst) begin
      s_tvalid  <= 1'b0;
      s_tdata   <= '0;
      s_tuser   <= '0;
      cfg_valid <= 1'b0;
      cfg_data  <= '0;
      hold_req  <= 1'b0;
      offering = 1'b0;
      cfg_busy = 1'b0;
      settle = 0;
    end else begin
      hold_now = 1'b0;
      settle = (pending_results.size() == 0) ? settle + 1 : 0;
      if (s_tvalid && s_tready) begin
        track_action(s_tuser, s_tdata);
        offering = 1'b0;
        settle = 0;
      end
      if (cfg_valid && cfg_ready) begin
        total_cfg = cfg_data;
        cfg_busy = 1'b0;
      end
      if (!offering && !cfg_busy && stim_q.size() > 0) begin
        case (stim_q[0].kind)
          OP_ITEM: begin
            if ($urandom_range(99) >= send_idle_pct) begin
              op = stim_q.pop_front();
              nxt_action = op.action;
              nxt_seq = op.seq;
              offering = 1'b1;
            end
          end
          OP_MODE: begin
            op = stim_q.pop_front();
            send_idle_pct = op.send_idle;
            stall_pct <= op.stall;
            hold_now = op.hold;
          end
          default: begin
            // wait out any action that produces no beat
            if (settle > SETTLE_CYCLES) begin
              op = stim_q.pop_front();
              if (op.kind == OP_CFG) begin
                nxt_total = op.total;
                cfg_busy = 1'b1;
              end
              settle = 0;
            end
          end
        endcase
      end
      s_tvalid  <= offering;
      s_tdata   <= nxt_seq;
      s_tuser   <= nxt_action;
      cfg_valid <= cfg_busy;
      cfg_data  <= nxt_total;
      hold_req  <= hold_now;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    int hold_left;
    if (rst) begin
      m_tready <= 1'b0;
      hold_left = 0;
    end else begin
      if (hold_req) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Monitor: compare each result beat with the oldest prediction
  always @(posedge clk) begin
    gap_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected beat status %0d", m_tuser));
      end else begin
        want = pending_results.pop_front();
        compare_field("status", m_tuser, want.status);
        compare_field("range_start", m_tdata[12:0], want.range_start);
        compare_field("range_end", m_tdata[25:13], want.range_end);
        compare_field("received_count", m_tdata[38:26], want.count);
        compare_field("pad", m_tdata[39], 0);
        compare_field("last", m_tlast, want.last);
      end
    end
  end

  int item_count = 0;

  task automatic push_item(logic [1:0] action, int seq);
    stim_op_t op;
    op = '{kind: OP_ITEM, action: action, seq: seq[SEQ_W-1:0], total: '0,
           send_idle: 0, stall: 0, hold: 1'b0};
    stim_q.push_back(op);
    if (action != ACT_UNUSED) item_count++;
  endtask

  task automatic push_cfg(int total);
    stim_op_t op;
    op = '{kind: OP_CFG, action: '0, seq: '0, total: total[CNT_W-1:0],
           send_idle: 0, stall: 0, hold: 1'b0};
    stim_q.push_back(op);
  endtask

  task automatic push_mode(int send_idle, int stall, bit hold);
    stim_op_t op;
    op = '{kind: OP_MODE, action: '0, seq: '0, total: '0,
           send_idle: send_idle, stall: stall, hold: hold};
    stim_q.push_back(op);
  endtask

  task automatic push_sync();
    stim_op_t op;
    op = '{kind: OP_SYNC, action: '0, seq: '0, total: '0,
           send_idle: 0, stall: 0, hold: 1'b0};
    stim_q.push_back(op);
  endtask

  // Stimulus and end of run
  initial begin
    int comb[48];
    int tmp;
    int j;
    int total;
    int eff;
    int n;
    int r;
    int phase;

    // directed: empty transfer, small transfer, largest and oversized totals
    push_mode(0, 0, 1'b0);
    push_item(ACT_REPORT, 0);
    push_item(ACT_CHUNK, 0);
    push_cfg(8);
    push_item(ACT_START, 16'hFFFF);
    push_item(ACT_CHUNK, 0);
    push_item(ACT_CHUNK, 7);
    push_item(ACT_CHUNK, 7);
    push_item(ACT_CHUNK, 8);
    push_item(ACT_CHUNK, 16'hFFFF);
    push_item(ACT_UNUSED, 16'h5A5A);
    push_item(ACT_REPORT, 0);
    for (int i = 1; i < 7; i++) push_item(ACT_CHUNK, i);
    push_item(ACT_REPORT, 0);
    push_cfg(MAX_CHUNKS);
    push_item(ACT_START, 0);
    push_item(ACT_CHUNK, MAX_CHUNKS - 1);
    push_item(ACT_CHUNK, 0);
    push_item(ACT_REPORT, 0);
    push_cfg(8191);
    push_item(ACT_CHUNK, MAX_CHUNKS);
    push_item(ACT_CHUNK, MAX_CHUNKS - 2);
    push_item(ACT_REPORT, 0);

    // comb of odd chunks: range limit hit, trailing gap dropped, then kept
    push_mode(31, 31, 1'b0);
    push_cfg(120);
    push_item(ACT_START, 0);
    for (int i = 0; i < 48; i++) comb[i] = 2 * i + 1;
    for (int i = 47; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = comb[i];
      comb[i] = comb[j];
      comb[j] = tmp;
    end
    for (int i = 0; i < 48; i++) push_item(ACT_CHUNK, comb[i]);
    push_item(ACT_REPORT, 0);
    push_item(ACT_CHUNK, 94);
    push_item(ACT_REPORT, 0);

    // long receiver hold-off while beats keep coming, then sender drains
    push_mode(0, 0, 1'b1);
    for (int i = 0; i < 6; i++) push_item(ACT_CHUNK, $urandom_range(119));
    push_item(ACT_REPORT, 0);
    push_item(ACT_CHUNK, $urandom);
    push_sync();

    // random transfers under rotating idle patterns
    phase = 1;
    while (item_count < RANDOM_ITEMS) begin
      case (phase % 4)
        0: push_mode(0, 0, 1'b0);
        1: push_mode(59, 0, 1'b0);
        2: push_mode(0, 59, 1'b0);
        default: push_mode(31, 31, 1'b0);
      endcase
      if (phase % 5 == 4) total = $urandom_range(8191);
      else total = $urandom_range(40);
      push_cfg(total);
      eff = (total > MAX_CHUNKS) ? MAX_CHUNKS : total;
      push_item(ACT_START, $urandom);
      n = $urandom_range(4, 14);
      for (int k = 0; k < n; k++) begin
        r = $urandom_range(99);
        if (r < 75 && eff > 0) push_item(ACT_CHUNK, $urandom_range(eff - 1));
        else if (r < 85) push_item(ACT_CHUNK, $urandom);
        else if (r < 93) push_item(ACT_REPORT, $urandom);
        else if (r < 97) push_item(ACT_UNUSED, $urandom);
        else push_item(ACT_START, $urandom);
      end
      push_item(ACT_REPORT, $urandom);
      phase++;
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (stim_q.size() != 0 || offering || cfg_busy || pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("chunk_receive_gap_tracker: match");
    end else begin
      $display("chunk_receive_gap_tracker: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("chunk_receive_gap_tracker: mismatch");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/ctgt_pkg.sv
rtl/ctgt_map_ram.sv
rtl/ctgt_word_scan.sv
rtl/chunk_receive_gap_tracker.sv
tb/sv/tb_chunk_receive_gap_tracker.sv
